// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define FPID_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define FPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/fpid_pkg.sv =====
// shared constants, codes and command types of the filtered pid controller
package fpid_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_W           = 24;
  localparam int ALPHA_W          = 17;
  localparam int COEF_W           = GAIN_W + 1;
  localparam int CFG_DATA_W       = 24;
  localparam int CFG_INDEX_W      = 3;
  localparam int FRAC_W           = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]  KI_RST    = '0;
  localparam logic [GAIN_W-1:0]  KD_RST    = '0;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(65536);
  localparam int                 OUT_MAX_RST = 32767;
  localparam int                 OUT_MIN_RST = -32768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KP         = 3'd0,
    CFG_KI_TS      = 3'd1,
    CFG_KD_OVER_TS = 3'd2,
    CFG_ALPHA_SP   = 3'd3,
    CFG_ALPHA_D    = 3'd4,
    CFG_OUT_MAX    = 3'd5,
    CFG_OUT_MIN    = 3'd6
  } cfg_index_e_t;

  typedef enum logic [2:0] {
    MUL_SEL_SP,
    MUL_SEL_P,
    MUL_SEL_I,
    MUL_SEL_EF,
    MUL_SEL_D
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_sf;
    logic     take_p;
    logic     upd_integ;
    logic     upd_ef;
    logic     upd_prev;
    logic     do_sum;
    logic     do_fix;
  } cmd_t;

endpackage

// ===== rtl/fpid_cfg.sv =====
// configuration register bank
module fpid_cfg #(
  parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fpid_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fpid_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [fpid_pkg::GAIN_W-1:0]          kp,
  output logic [fpid_pkg::GAIN_W-1:0]          ki_ts,
  output logic [fpid_pkg::GAIN_W-1:0]          kd_over_ts,
  output logic [fpid_pkg::ALPHA_W-1:0]         alpha_sp,
  output logic [fpid_pkg::ALPHA_W-1:0]         alpha_d,
  output logic signed [SAMPLE_WIDTH-1:0]       out_max,
  output logic signed [SAMPLE_WIDTH-1:0]       out_min
);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= fpid_pkg::KP_RST;
      ki_ts      <= fpid_pkg::KI_RST;
      kd_over_ts <= fpid_pkg::KD_RST;
      alpha_sp   <= fpid_pkg::ALPHA_RST;
      alpha_d    <= fpid_pkg::ALPHA_RST;
      out_max    <= SAMPLE_WIDTH'(fpid_pkg::OUT_MAX_RST);
      out_min    <= SAMPLE_WIDTH'(fpid_pkg::OUT_MIN_RST);
    end else if (cfg_write) begin
      case (fpid_pkg::cfg_index_e_t'(cfg_index))
        fpid_pkg::CFG_KP:         kp         <= cfg_data[fpid_pkg::GAIN_W-1:0];
        fpid_pkg::CFG_KI_TS:      ki_ts      <= cfg_data[fpid_pkg::GAIN_W-1:0];
        fpid_pkg::CFG_KD_OVER_TS: kd_over_ts <= cfg_data[fpid_pkg::GAIN_W-1:0];
        fpid_pkg::CFG_ALPHA_SP:   alpha_sp   <= cfg_data[fpid_pkg::ALPHA_W-1:0];
        fpid_pkg::CFG_ALPHA_D:    alpha_d    <= cfg_data[fpid_pkg::ALPHA_W-1:0];
        fpid_pkg::CFG_OUT_MAX:    out_max    <= cfg_data[SAMPLE_WIDTH-1:0];
        fpid_pkg::CFG_OUT_MIN:    out_min    <= cfg_data[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fpid_ctrl.sv =====
// control sequencer: steps one sample through the shared multiplier
module fpid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_stall,
  output logic           result_valid,
  input  logic           result_stall,
  output fpid_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SP,
    ST_UPD_SF,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_EF,
    ST_UPD_EF,
    ST_MUL_D,
    ST_SUM,
    ST_FIX
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = (state != ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = fpid_pkg::MUL_SEL_SP;
    case (state)
      ST_IDLE:   cmd.load_in = sample_valid;
      ST_MUL_SP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fpid_pkg::MUL_SEL_SP;
      end
      ST_UPD_SF: cmd.upd_sf = 1'b1;
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fpid_pkg::MUL_SEL_P;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fpid_pkg::MUL_SEL_I;
        cmd.take_p  = 1'b1;
      end
      ST_MUL_EF: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = fpid_pkg::MUL_SEL_EF;
        cmd.upd_integ = 1'b1;
      end
      ST_UPD_EF: cmd.upd_ef = 1'b1;
      ST_MUL_D: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = fpid_pkg::MUL_SEL_D;
        cmd.upd_prev = 1'b1;
      end
      ST_SUM:    cmd.do_sum = 1'b1;
      ST_FIX:    cmd.do_fix = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      // a new result may replace one that leaves in the same cycle
      if ((state == ST_FIX) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= ST_MUL_SP;
          end
        end
        ST_MUL_SP: state <= ST_UPD_SF;
        ST_UPD_SF: state <= ST_MUL_P;
        ST_MUL_P:  state <= ST_MUL_I;
        ST_MUL_I:  state <= ST_MUL_EF;
        ST_MUL_EF: state <= ST_UPD_EF;
        ST_UPD_EF: state <= ST_MUL_D;
        ST_MUL_D:  state <= ST_SUM;
        ST_SUM:    state <= ST_FIX;
        ST_FIX: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fpid_dp.sv =====
// datapath: filter and integrator state, shared multiplier, output register
module fpid_dp #(
  parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpid_pkg::cmd_t                 cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0] feedback,
  input  logic [fpid_pkg::GAIN_W-1:0]    kp,
  input  logic [fpid_pkg::GAIN_W-1:0]    ki_ts,
  input  logic [fpid_pkg::GAIN_W-1:0]    kd_over_ts,
  input  logic [fpid_pkg::ALPHA_W-1:0]   alpha_sp,
  input  logic [fpid_pkg::ALPHA_W-1:0]   alpha_d,
  input  logic signed [SAMPLE_WIDTH-1:0] out_max,
  input  logic signed [SAMPLE_WIDTH-1:0] out_min,
  output logic signed [SAMPLE_WIDTH-1:0] drive,
  output logic                           saturated
);

  localparam int SQ = SAMPLE_WIDTH + fpid_pkg::FRAC_W;  // sample in q.16
  localparam int DW = ((SQ > 32) ? SQ : 32) + 2;        // multiplier data operand
  localparam int EW = DW - 1;                           // error width
  localparam int CW = fpid_pkg::COEF_W;
  localparam int PW = DW + CW;                          // full product
  localparam int QW = PW - fpid_pkg::FRAC_W;            // product after floor shift
  localparam int IW = QW + 2;                           // sums of up to three terms

  function automatic logic signed [31:0] sat32(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] mx;
    logic signed [IW-1:0] mn;
    mx = IW'($signed(32'h7FFF_FFFF));
    mn = IW'($signed(32'h8000_0000));
    if (v > mx) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < mn) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // upper bound is tested first, so inverted limits give one of the two
  function automatic logic signed [IW-1:0] clamp_lim(input logic signed [IW-1:0] v,
                                                     input logic signed [IW-1:0] lo,
                                                     input logic signed [IW-1:0] hi);
    if (v > hi) begin
      clamp_lim = hi;
    end else if (v < lo) begin
      clamp_lim = lo;
    end else begin
      clamp_lim = v;
    end
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] sp_q;
  logic signed [SAMPLE_WIDTH-1:0] fb_q;
  logic signed [31:0]             sf;
  logic signed [31:0]             prev;
  logic signed [31:0]             ef;
  logic signed [31:0]             integ;
  logic signed [EW-1:0]           err;
  logic signed [QW-1:0]           prod_q;
  logic signed [QW-1:0]           p_term;
  logic signed [QW-1:0]           inc;
  logic signed [SQ-1:0]           sum_q;

  logic signed [SQ-1:0]           sp_fix;
  logic signed [SQ-1:0]           fb_fix;
  logic signed [SQ-1:0]           hi_fix;
  logic signed [SQ-1:0]           lo_fix;
  logic signed [IW-1:0]           hi_w;
  logic signed [IW-1:0]           lo_w;
  logic [fpid_pkg::ALPHA_W-1:0]   alpha_sp_eff;
  logic [fpid_pkg::ALPHA_W-1:0]   alpha_d_eff;
  logic signed [CW-1:0]           coef;
  logic signed [DW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_full;
  logic signed [31:0]             sf_new;
  logic signed [EW-1:0]           err_next;
  logic signed [IW-1:0]           sum_raw;
  logic                           at_limit;

  assign sp_fix = {sp_q, 16'h0000};
  assign fb_fix = {fb_q, 16'h0000};
  assign hi_fix = {out_max, 16'h0000};
  assign lo_fix = {out_min, 16'h0000};
  assign hi_w   = IW'(hi_fix);
  assign lo_w   = IW'(lo_fix);

  // coefficients above one act as one
  assign alpha_sp_eff = (alpha_sp > fpid_pkg::ALPHA_ONE) ? fpid_pkg::ALPHA_ONE : alpha_sp;
  assign alpha_d_eff  = (alpha_d > fpid_pkg::ALPHA_ONE) ? fpid_pkg::ALPHA_ONE : alpha_d;

  always_comb begin
    coef  = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      fpid_pkg::MUL_SEL_SP: begin
        coef  = $signed(CW'(alpha_sp_eff));
        mul_b = DW'(sp_fix) - DW'(sf);
      end
      fpid_pkg::MUL_SEL_P: begin
        coef  = $signed(CW'(kp));
        mul_b = DW'(err);
      end
      fpid_pkg::MUL_SEL_I: begin
        coef  = $signed(CW'(ki_ts));
        mul_b = DW'(err);
      end
      fpid_pkg::MUL_SEL_EF: begin
        coef  = $signed(CW'(alpha_d_eff));
        mul_b = DW'(err) - DW'(prev);
      end
      fpid_pkg::MUL_SEL_D: begin
        coef  = $signed(CW'(kd_over_ts));
        mul_b = DW'(ef) - DW'(prev);
      end
      default: ;
    endcase
  end

  assign mul_full = coef * mul_b;
  assign sf_new   = sat32(IW'(sf) + IW'(prod_q));
  assign err_next = EW'(sf_new) - EW'(fb_fix);
  assign sum_raw  = IW'(p_term) + IW'(integ) + IW'(prod_q);
  assign at_limit = (sum_q == hi_fix) || (sum_q == lo_fix);

  // filter and integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      sf    <= '0;
      prev  <= '0;
      integ <= '0;
    end else begin
      if (cmd.upd_sf) begin
        sf <= sf_new;
      end
      if (cmd.upd_prev) begin
        prev <= ef;
      end
      if (cmd.upd_integ) begin
        integ <= sat32(clamp_lim(IW'(integ) + IW'(prod_q), lo_w, hi_w));
      end else if (cmd.do_fix && at_limit) begin
        // anti-windup: take back this step's increment
        integ <= sat32(clamp_lim(IW'(integ) - IW'(inc), lo_w, hi_w));
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sp_q <= setpoint;
      fb_q <= feedback;
    end
    if (cmd.mul_en) begin
      prod_q <= QW'(mul_full >>> fpid_pkg::FRAC_W);
    end
    if (cmd.upd_sf) begin
      err <= err_next;
    end
    if (cmd.take_p) begin
      p_term <= prod_q;
    end
    if (cmd.upd_integ) begin
      inc <= prod_q;
    end
    if (cmd.upd_ef) begin
      ef <= sat32(IW'(prev) + IW'(prod_q));
    end
    if (cmd.do_sum) begin
      sum_q <= SQ'(clamp_lim(sum_raw, lo_w, hi_w));
    end
    if (cmd.do_fix) begin
      drive     <= sum_q[SQ-1:fpid_pkg::FRAC_W];
      saturated <= at_limit;
    end
  end

endmodule

// ===== rtl/filtered_pid_controller_unit.sv =====
// top level of the filtered positional pid controller
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------
//   sample   | sample_valid / sample_stall | setpoint, feedback
//   result   | result_valid / result_stall | drive, saturated
//   config   | cfg_write                   | cfg_index, cfg_data
//
// a request is accepted in the idle state, then passes through nine steps of the
// sequencer, five of which go through the one shared multiplier
// a finished result waits in the output register; the next request is taken
// meanwhile and only the last step holds while that register is still full
// synchronous active-high reset clears the filter and integrator state and
// loads the register defaults; no clearing pass is needed
`include "assert_macros.svh"

module filtered_pid_controller_unit #(
  parameter int SAMPLE_WIDTH = fpid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0]     feedback,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     drive,
  output logic                               saturated,
  // register write port
  input  logic                               cfg_write,
  input  logic [fpid_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // register bank outputs
  logic [fpid_pkg::GAIN_W-1:0]    kp;
  logic [fpid_pkg::GAIN_W-1:0]    ki_ts;
  logic [fpid_pkg::GAIN_W-1:0]    kd_over_ts;
  logic [fpid_pkg::ALPHA_W-1:0]   alpha_sp;
  logic [fpid_pkg::ALPHA_W-1:0]   alpha_d;
  logic signed [SAMPLE_WIDTH-1:0] out_max;
  logic signed [SAMPLE_WIDTH-1:0] out_min;

  // step commands from the sequencer to the datapath
  fpid_pkg::cmd_t cmd;

  // state-changing steps, gathered for the exclusivity check
  logic [4:0] step_flags;

  assign step_flags = {cmd.load_in, cmd.upd_sf, cmd.upd_ef, cmd.do_sum, cmd.do_fix};

  fpid_cfg #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kp         (kp),
    .ki_ts      (ki_ts),
    .kd_over_ts (kd_over_ts),
    .alpha_sp   (alpha_sp),
    .alpha_d    (alpha_d),
    .out_max    (out_max),
    .out_min    (out_min)
  );

  // sequencer: owns the handshake and the step order
  fpid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // datapath: setpoint filter, error, p/i/d terms, saturation, anti-windup
  fpid_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .setpoint   (setpoint),
    .feedback   (feedback),
    .kp         (kp),
    .ki_ts      (ki_ts),
    .kd_over_ts (kd_over_ts),
    .alpha_sp   (alpha_sp),
    .alpha_d    (alpha_d),
    .out_max    (out_max),
    .out_min    (out_min),
    .drive      (drive),
    .saturated  (saturated)
  );

  // an accepted request keeps the sample side busy on the next cycle
  `FPID_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample_valid && !sample_stall, sample_stall)

  // a new result only appears after the final step loaded the output register
  `FPID_ASSERT_NOW(a_result_from_fix, clk, rst, $rose(result_valid), $past(cmd.do_fix))

  // the final step never overwrites a result still waiting downstream
  `FPID_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.do_fix, !result_valid || !result_stall)

  // state-changing steps belong to distinct sequencer states
  `FPID_ASSERT_NOW(a_steps_exclusive, clk, rst, 1'b1, $onehot0(step_flags))

endmodule
